### sv/mm_pkg.sv
package mm_pkg;

    // Field widths of the item, result and configuration channels.
    localparam int ELEM_W    = 16;
    localparam int VALUE_W   = 35;
    localparam int OUT_IDX_W = 3;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    // Limits of the signed Q19.16 result.
    localparam logic signed [63:0] VALUE_MAX = 64'sd17179869183;
    localparam logic signed [63:0] VALUE_MIN = -64'sd17179869184;

    // Control that travels with one operand pair into the MAC.
    typedef struct packed {
        logic valid;
        logic first;
    } mac_ctrl_t;

endpackage

### sv/mm_ram.sv
module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/mm_mac.sv
module mm_mac import mm_pkg::*; #(
    parameter int ACC_W = 36
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mac_ctrl_t                 ctrl,
    input  logic signed [ELEM_W-1:0]  a,
    input  logic signed [ELEM_W-1:0]  b,
    output logic                      busy,
    output logic signed [VALUE_W-1:0] sum
);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(VALUE_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(VALUE_MIN);

    logic signed [2*ELEM_W-1:0] prod_reg;
    logic signed [2*ELEM_W-1:0] prod_next;
    mac_ctrl_t                  pctrl_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [ACC_W-1:0]    prod_ext;

    // Multiply stage, then accumulate stage on the registered product.
    always_comb
    begin
        prod_next = a * b;
        prod_ext  = {{(ACC_W-2*ELEM_W){prod_reg[2*ELEM_W-1]}}, prod_reg};
        acc_next  = acc_reg;
        if (pctrl_reg.valid)
        begin
            acc_next = pctrl_reg.first ? prod_ext : acc_reg + prod_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pctrl_reg <= '0;
        end
        else
        begin
            pctrl_reg <= ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // Clamp the running sum to the result range.
    always_comb
    begin
        if (acc_reg > SAT_HI)
        begin
            sum = VALUE_W'(SAT_HI);
        end
        else if (acc_reg < SAT_LO)
        begin
            sum = VALUE_W'(SAT_LO);
        end
        else
        begin
            sum = VALUE_W'(acc_reg);
        end
    end

    assign busy = pctrl_reg.valid;

endmodule

### sv/matrix_multiply_top.sv
// Fixed-point matrix product A times B.
// Set rows_a, inner_dim and cols_b on the configuration port (index 0, 1, 2)
// while the block is idle; a value of 0 acts as 1 and one above MAX_DIM acts
// as MAX_DIM, and every write to one of these three restarts loading. Then
// send the elements of A and after them those of B, one signed Q8.8 item
// each, row-major, on the in_valid/in_stall channel. After the last element
// of B, the product comes out in row-major order on out_valid/out_stall, with
// row and column on every element and out_last on the final one. Each result
// goes through the one shared multiply-accumulate unit, inner_dim operand
// pairs at one product per cycle from the two store read ports; then the
// unit's pipeline drains and the result is handed over.
// The block takes no item while it computes or holds a result; a stall on
// the output simply holds the result and the sequencer waits. Reset sets all
// dimensions to 1 and returns the block to loading with nothing taken.
module matrix_multiply_top import mm_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [ELEM_W-1:0]    elem_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [OUT_IDX_W-1:0]        out_row,
    output logic [OUT_IDX_W-1:0]        out_col,
    output logic signed [VALUE_W-1:0]   out_value,
    output logic                        out_last
);

    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int ACC_RAW = 2 * ELEM_W + $clog2(MAX_DIM) + 1;
    localparam int ACC_W   = (ACC_RAW > VALUE_W) ? ACC_RAW : VALUE_W + 1;

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_DRAIN = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        if (v == '0)
        begin
            return DIM_W'(1);
        end
        if (32'(v) > MAX_DIM)
        begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
        return ADDR_W'(32'(row) * MAX_DIM + 32'(col));
    endfunction

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    rows_a_reg, rows_a_next;
    logic [CFG_W-1:0]    inner_dim_reg, inner_dim_next;
    logic [CFG_W-1:0]    cols_b_reg, cols_b_next;
    logic                ld_phase_b_reg, ld_phase_b_next;
    logic [IDX_W-1:0]    ld_row_reg, ld_row_next;
    logic [IDX_W-1:0]    ld_col_reg, ld_col_next;
    logic [IDX_W-1:0]    cr_reg, cr_next;
    logic [IDX_W-1:0]    cc_reg, cc_next;
    logic [IDX_W-1:0]    ck_reg, ck_next;
    mac_ctrl_t           issue_ctrl_reg, issue_ctrl_next;
    logic [OUT_IDX_W-1:0] out_row_reg, out_row_next;
    logic [OUT_IDX_W-1:0] out_col_reg, out_col_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic                out_last_reg, out_last_next;

    logic [IDX_W-1:0]    ra_last;
    logic [IDX_W-1:0]    id_last;
    logic [IDX_W-1:0]    cb_last;
    logic                in_acc;
    logic                cfg_hit;
    logic                wr_a_en;
    logic                wr_b_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr_a;
    logic [ADDR_W-1:0]   rd_addr_b;
    logic [ELEM_W-1:0]   rd_data_a;
    logic [ELEM_W-1:0]   rd_data_b;
    logic                mac_busy;
    logic                pipe_busy;
    logic signed [VALUE_W-1:0] mac_sum;

    // Effective dimensions, as last-index values.
    assign ra_last = IDX_W'(clamp_dim(rows_a_reg) - DIM_W'(1));
    assign id_last = IDX_W'(clamp_dim(inner_dim_reg) - DIM_W'(1));
    assign cb_last = IDX_W'(clamp_dim(cols_b_reg) - DIM_W'(1));

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_LOAD);
    assign in_acc    = in_valid && (state_reg == S_LOAD);
    assign pipe_busy = issue_ctrl_reg.valid || mac_busy;
    assign rd_en     = (state_reg == S_ISSUE);
    assign rd_addr_a = addr_of(cr_reg, ck_reg);
    assign rd_addr_b = addr_of(ck_reg, cc_reg);
    assign wr_addr   = addr_of(ld_row_reg, ld_col_reg);
    assign wr_a_en   = in_acc && !ld_phase_b_reg;
    assign wr_b_en   = in_acc && ld_phase_b_reg;

    // Sequencer: load counters, compute counters and result register.
    always_comb
    begin
        state_next      = state_reg;
        rows_a_next     = rows_a_reg;
        inner_dim_next  = inner_dim_reg;
        cols_b_next     = cols_b_reg;
        ld_phase_b_next = ld_phase_b_reg;
        ld_row_next     = ld_row_reg;
        ld_col_next     = ld_col_reg;
        cr_next         = cr_reg;
        cc_next         = cc_reg;
        ck_next         = ck_reg;
        issue_ctrl_next = '0;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        cfg_hit         = 1'b0;

        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (!ld_phase_b_reg)
                    begin
                        // Walking A: inner_dim columns per row, rows_a rows.
                        if (ld_col_reg == id_last)
                        begin
                            ld_col_next = '0;
                            if (ld_row_reg == ra_last)
                            begin
                                ld_row_next     = '0;
                                ld_phase_b_next = 1'b1;
                            end
                            else
                            begin
                                ld_row_next = ld_row_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            ld_col_next = ld_col_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        // Walking B: cols_b columns per row, inner_dim rows.
                        if (ld_col_reg == cb_last)
                        begin
                            ld_col_next = '0;
                            if (ld_row_reg == id_last)
                            begin
                                ld_row_next     = '0;
                                ld_phase_b_next = 1'b0;
                                cr_next         = '0;
                                cc_next         = '0;
                                ck_next         = '0;
                                state_next      = S_ISSUE;
                            end
                            else
                            begin
                                ld_row_next = ld_row_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            ld_col_next = ld_col_reg + 1'b1;
                        end
                    end
                end
            end
            S_ISSUE:
            begin
                // One operand pair per cycle into the MAC.
                issue_ctrl_next.valid = 1'b1;
                issue_ctrl_next.first = (ck_reg == '0);
                if (ck_reg == id_last)
                begin
                    ck_next    = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    ck_next = ck_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    out_row_next   = OUT_IDX_W'(cr_reg);
                    out_col_next   = OUT_IDX_W'(cc_reg);
                    out_value_next = mac_sum;
                    out_last_next  = (cr_reg == ra_last) && (cc_reg == cb_last);
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    if (out_last_reg)
                    begin
                        cr_next    = '0;
                        cc_next    = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        if (cc_reg == cb_last)
                        begin
                            cc_next = '0;
                            cr_next = cr_reg + 1'b1;
                        end
                        else
                        begin
                            cc_next = cc_reg + 1'b1;
                        end
                        ck_next    = '0;
                        state_next = S_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // Register writes; any known register restarts loading.
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ROWS_A:
                begin
                    rows_a_next = cfg_data;
                    cfg_hit     = 1'b1;
                end
                REG_INNER_DIM:
                begin
                    inner_dim_next = cfg_data;
                    cfg_hit        = 1'b1;
                end
                REG_COLS_B:
                begin
                    cols_b_next = cfg_data;
                    cfg_hit     = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
            if (cfg_hit)
            begin
                ld_phase_b_next = 1'b0;
                ld_row_next     = '0;
                ld_col_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            rows_a_reg     <= CFG_W'(1);
            inner_dim_reg  <= CFG_W'(1);
            cols_b_reg     <= CFG_W'(1);
            ld_phase_b_reg <= 1'b0;
            ld_row_reg     <= '0;
            ld_col_reg     <= '0;
            cr_reg         <= '0;
            cc_reg         <= '0;
            ck_reg         <= '0;
            issue_ctrl_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rows_a_reg     <= rows_a_next;
            inner_dim_reg  <= inner_dim_next;
            cols_b_reg     <= cols_b_next;
            ld_phase_b_reg <= ld_phase_b_next;
            ld_row_reg     <= ld_row_next;
            ld_col_reg     <= ld_col_next;
            cr_reg         <= cr_next;
            cc_reg         <= cc_next;
            ck_reg         <= ck_next;
            issue_ctrl_reg <= issue_ctrl_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = (state_reg == S_OUT);
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

    // Element stores for A and B.
    mm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_store_a (
        .clk     (clk),
        .wr_en   (wr_a_en),
        .wr_addr (wr_addr),
        .wr_data (elem_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    mm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_store_b (
        .clk     (clk),
        .wr_en   (wr_b_en),
        .wr_addr (wr_addr),
        .wr_data (elem_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

    // Shared multiply-accumulate unit.
    mm_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (issue_ctrl_reg),
        .a     (rd_data_a),
        .b     (rd_data_b),
        .busy  (mac_busy),
        .sum   (mac_sum)
    );

`ifndef ASSERT_OFF
    // No item is taken while a result is on offer.
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("item accepted while a result is pending");

    // Handing over the final result reopens the input.
    a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_last) |=> !in_stall)
        else $error("input not reopened after final result");

    // Operand pairs enter the MAC only from the issue phase.
    a_issue_origin: assert property (@(posedge clk) disable iff (!rst_n)
        issue_ctrl_reg.valid |-> $past(state_reg == S_ISSUE))
        else $error("MAC fed outside the issue phase");

    // A result is captured only after the MAC pipeline has drained.
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!pipe_busy))
        else $error("result captured before MAC drained");
`endif

endmodule

### tb/mm_checker.sv
module mm_checker import mm_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic signed [ELEM_W-1:0]    elem_value,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [OUT_IDX_W-1:0]        out_row,
    input  logic [OUT_IDX_W-1:0]        out_col,
    input  logic signed [VALUE_W-1:0]   out_value,
    input  logic                        out_last,
    output int                          error_count,
    output int                          pending_count
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    // One element of the product as it should leave the block.
    typedef struct packed {
        logic [OUT_IDX_W-1:0]      row;
        logic [OUT_IDX_W-1:0]      col;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } product_elem_t;

    // Shadow copy of the block's registers, stores and load position.
    logic [CFG_W-1:0]         rows_reg;
    logic [CFG_W-1:0]         inner_reg;
    logic [CFG_W-1:0]         cols_reg;
    logic signed [ELEM_W-1:0] mat_a [DEPTH];
    logic signed [ELEM_W-1:0] mat_b [DEPTH];
    int unsigned              elems_taken;
    product_elem_t            product_q[$];
    int                       mismatches;

    // A dimension of 0 acts as 1, and one above MAX_DIM is clamped.
    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (32'(v) > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    // Store one element and, on the last element of B, queue the whole product.
    task automatic take_elem(input logic signed [ELEM_W-1:0] v);
        int unsigned   ra;
        int unsigned   id;
        int unsigned   cb;
        int unsigned   size_a;
        int unsigned   total;
        int unsigned   pos;
        int unsigned   j;
        longint        acc;
        product_elem_t pe;
        ra = clamp_dim(rows_reg);
        id = clamp_dim(inner_reg);
        cb = clamp_dim(cols_reg);
        size_a = ra * id;
        total = size_a + id * cb;
        pos = (elems_taken >= total) ? 0 : elems_taken;
        if (pos < size_a)
        begin
            mat_a[(pos / id) * MAX_DIM + (pos % id)] = v;
        end
        else
        begin
            j = pos - size_a;
            mat_b[(j / cb) * MAX_DIM + (j % cb)] = v;
        end
        if (pos + 1 < total)
        begin
            elems_taken = (pos + 1) & 8'hFF;
        end
        else
        begin
            elems_taken = 0;
            for (int r = 0; r < ra; r++)
            begin
                for (int c = 0; c < cb; c++)
                begin
                    acc = 0;
                    for (int k = 0; k < id; k++)
                    begin
                        acc += longint'(mat_a[r * MAX_DIM + k]) *
                               longint'(mat_b[k * MAX_DIM + c]);
                    end
                    if (acc > VALUE_MAX)
                        acc = VALUE_MAX;
                    if (acc < VALUE_MIN)
                        acc = VALUE_MIN;
                    pe.row = r[OUT_IDX_W-1:0];
                    pe.col = c[OUT_IDX_W-1:0];
                    pe.value = acc[VALUE_W-1:0];
                    pe.last = (r + 1 == ra) && (c + 1 == cb);
                    product_q.push_back(pe);
                end
            end
        end
    endtask

    // Compare one accepted result with the oldest expected product element.
    task automatic check_result();
        product_elem_t pe;
        if (product_q.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual row %0d col %0d value %0d",
                     $time, out_row, out_col, out_value);
            mismatches++;
        end
        else
        begin
            pe = product_q.pop_front();
            if (out_row !== pe.row)
            begin
                $display("%0t: out_row mismatch, expected %0d, actual %0d",
                         $time, pe.row, out_row);
                mismatches++;
            end
            if (out_col !== pe.col)
            begin
                $display("%0t: out_col mismatch, expected %0d, actual %0d",
                         $time, pe.col, out_col);
                mismatches++;
            end
            if (out_value !== pe.value)
            begin
                $display("%0t: out_value mismatch, expected %0d, actual %0d",
                         $time, pe.value, out_value);
                mismatches++;
            end
            if (out_last !== pe.last)
            begin
                $display("%0t: out_last mismatch, expected %0d, actual %0d",
                         $time, pe.last, out_last);
                mismatches++;
            end
        end
    endtask

    // Watch the three channels and keep the prediction in step.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg = CFG_W'(1);
            inner_reg = CFG_W'(1);
            cols_reg = CFG_W'(1);
            elems_taken = 0;
            mismatches = 0;
            product_q.delete();
            for (int i = 0; i < DEPTH; i++)
            begin
                mat_a[i] = '0;
                mat_b[i] = '0;
            end
            error_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ROWS_A:
                    begin
                        rows_reg = cfg_data;
                        elems_taken = 0;
                    end
                    REG_INNER_DIM:
                    begin
                        inner_reg = cfg_data;
                        elems_taken = 0;
                    end
                    REG_COLS_B:
                    begin
                        cols_reg = cfg_data;
                        elems_taken = 0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
                take_elem(elem_value);
            if (out_valid && !out_stall)
                check_result();
            error_count <= mismatches;
            pending_count <= product_q.size();
        end
    end

endmodule

### tb/matrix_multiply_top_tb.sv
module matrix_multiply_top_tb import mm_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM = 8;
    localparam int RANDOM_ELEMS = 250;
    localparam int CALM_AFTER = 200;
    localparam int SETTLE_CYCLES = MAX_DIM + 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [ELEM_W-1:0]  elem_value;
    logic                      out_valid;
    logic                      out_stall;
    logic [OUT_IDX_W-1:0]      out_row;
    logic [OUT_IDX_W-1:0]      out_col;
    logic signed [VALUE_W-1:0] out_value;
    logic                      out_last;
    int                        error_count;
    int                        pending_count;

    // Shared knobs between the sender and the receiver.
    logic                      gaps_on;
    logic                      long_hold_req;

    matrix_multiply_top #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .elem_value(elem_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_row(out_row),
        .out_col(out_col),
        .out_value(out_value),
        .out_last(out_last)
    );

    mm_checker #(
        .MAX_DIM(MAX_DIM)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .elem_value(elem_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_row(out_row),
        .out_col(out_col),
        .out_value(out_value),
        .out_last(out_last),
        .error_count(error_count),
        .pending_count(pending_count)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("matrix_multiply_top_tb: done, errors");
        $finish;
    end

    // Dimension as the block uses it, for sizing runs.
    function automatic int unsigned dim_used(logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (32'(v) > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    // Mostly small dimensions, now and then zero or a larger value of 5 to 15.
    function automatic logic [CFG_W-1:0] pick_dim();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 8)
            return CFG_W'($urandom_range(1, 4));
        if (sel == 8)
            return '0;
        return CFG_W'($urandom_range(5, 15));
    endfunction

    // Element values with the extremes weighted in.
    function automatic logic signed [ELEM_W-1:0] pick_elem();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // Write one register and wait for the handshake.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Offer one element, with an occasional gap before it.
    task automatic send_elem(input logic signed [ELEM_W-1:0] v);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        elem_value <= v;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Send a number of random elements in a row, with any gaps send_elem adds.
    task automatic send_elems(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_elem(pick_elem());
    endtask

    // Stop offering, wait for every expected result, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        logic hold_taken;
        hold_taken = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int unsigned      elems_done;
        int unsigned      run_len;
        int unsigned      part_len;
        int unsigned      runs;
        logic             hold_used;
        logic [CFG_W-1:0] ra;
        logic [CFG_W-1:0] id;
        logic [CFG_W-1:0] cb;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        elem_value = '0;
        gaps_on = 1'b1;
        long_hold_req = 1'b0;
        elems_done = 0;
        hold_used = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset dimensions are 1 by 1 by 1: products of the extreme values.
        send_elem(16'sh7FFF);
        send_elem(16'sh7FFF);
        send_elem(16'sh8000);
        send_elem(16'sh8000);
        send_elem(16'sh8000);
        send_elem(16'sh7FFF);
        drain();

        // A zero inner dimension acts as 1; start a 2x1x2 run and abandon it.
        cfg_write(REG_ROWS_A, 4'd2);
        cfg_write(REG_INNER_DIM, 4'd0);
        cfg_write(REG_COLS_B, 4'd2);
        send_elem(16'sh4000);
        send_elem(-16'sd5);
        drain();

        // A write in the middle of loading restarts it; now 2x1x1.
        cfg_write(REG_COLS_B, 4'd0);
        send_elem(16'sh1234);
        send_elem(-16'sd1);
        send_elem(16'sh0100);
        drain();

        // The unused index changes nothing.
        cfg_write(REG_UNUSED, 4'hF);

        // An oversized row count acts as MAX_DIM: 8x1x1.
        cfg_write(REG_ROWS_A, 4'd9);
        cfg_write(REG_COLS_B, 4'd1);
        send_elem(16'sh7FFF);
        send_elem(16'sh8000);
        send_elem(16'sh0000);
        send_elem(-16'sd1);
        send_elem(16'sh0001);
        send_elem(16'shAAAA);
        send_elem(16'sh5555);
        send_elem(16'sh00FF);
        send_elem(16'sh8000);
        drain();

        // Random phases: new dimensions, a few full runs, sometimes a broken one.
        while (elems_done < RANDOM_ELEMS)
        begin
            if (elems_done >= CALM_AFTER)
                gaps_on = 1'b0;
            else
                gaps_on = ($urandom_range(0, 3) != 0);
            ra = pick_dim();
            id = pick_dim();
            cb = pick_dim();
            runs = $urandom_range(1, 3);
            if (!hold_used && elems_done > 60)
            begin
                // Hold the output long enough for the block to back up its input.
                ra = 4'd4;
                id = 4'd3;
                cb = 4'd4;
                runs = 2;
                hold_used = 1'b1;
            end
            cfg_write(REG_ROWS_A, ra);
            cfg_write(REG_INNER_DIM, id);
            cfg_write(REG_COLS_B, cb);
            if (hold_used && runs == 2 && ra == 4'd4 && id == 4'd3 && cb == 4'd4)
                long_hold_req = 1'b1;
            run_len = dim_used(ra) * dim_used(id) + dim_used(id) * dim_used(cb);
            for (int unsigned n = 0; n < runs; n++)
            begin
                send_elems(run_len);
                elems_done += run_len;
            end
            if ($urandom_range(0, 5) == 0)
            begin
                part_len = $urandom_range(1, run_len - 1);
                send_elems(part_len);
                elems_done += part_len;
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("matrix_multiply_top_tb: done, clean");
        else
            $display("matrix_multiply_top_tb: done, errors");
        $finish;
    end

endmodule

### filelist.f
sv/mm_pkg.sv
sv/mm_ram.sv
sv/mm_mac.sv
sv/matrix_multiply_top.sv
tb/mm_checker.sv
tb/matrix_multiply_top_tb.sv
